/* rtl/core/rmpc_pkg.sv */
// Shared constants and elaboration-time table functions for the Maxwell plot coordinate block.
package rmpc_pkg;

  localparam int unsigned FRAC_BITS_DEF = 20;
  localparam int unsigned MANT_BITS     = 30;
  localparam int unsigned SQ_LIMIT      = 27;

  // Integer square root, used only to build constants.
  function automatic longint unsigned isqrt_c(longint unsigned v_in);
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Base-2 logarithm of n in fixed point with f fraction bits, by repeated squaring.
  function automatic longint unsigned log2q(int n, int f);
    longint unsigned m;
    longint unsigned res;
    int k;
    int i;
    k = 0;
    while (k < 8 && (n >> (k + 1)) != 0) k++;
    m = (longint'(n) << MANT_BITS) >> k;
    res = longint'(k);
    for (i = 0; i < f; i++) begin
      m = (m * m) >> MANT_BITS;
      res = res << 1;
      if (m >= (64'd2 << MANT_BITS)) begin
        m = m >> 1;
        res = res | 64'd1;
      end
    end
    return res;
  endfunction

  // Log distance of one channel code from full scale; a zero code counts as one.
  function automatic longint unsigned log_x(int n, int f);
    return log2q(255, f) - log2q((n == 0) ? 1 : n, f);
  endfunction

  // Plot column for a first-axis value in hundredths (code given as 0..255).
  function automatic logic [8:0] plot_col(int code, int f);
    longint s2;
    longint h;
    longint v;
    longint q;
    s2 = longint'(isqrt_c(64'd1 << (2 * f + 1)));
    h  = (code > 127) ? longint'(code) - 256 : longint'(code);
    v  = (longint'(250) << f) + (250 * s2 * h) / 100;
    if (v <= 0) return 9'd0;
    q = v >> f;
    return (q > 511) ? 9'd511 : 9'(q);
  endfunction

  // Plot row for a second-axis value in hundredths (code given as 0..255).
  function automatic logic [8:0] plot_row(int code, int f);
    longint s23;
    longint h;
    longint v;
    longint q;
    s23 = longint'(isqrt_c((64'd1 << (2 * f + 1)) / 3));
    h   = (code > 127) ? longint'(code) - 256 : longint'(code);
    v   = (longint'(288) << f) - (432 * s23 * h) / 100;
    if (v <= 0) return 9'd0;
    q = v >> f;
    return (q > 511) ? 9'd511 : 9'(q);
  endfunction

  // Signed hundredths from a sign and a truncated magnitude, saturated to 8 bits.
  function automatic logic signed [7:0] hund(logic neg, logic [9:0] q);
    if (neg) begin
      return (q > 10'd128) ? -8'sd128 : -$signed(8'(q));
    end
    return (q > 10'd127) ? 8'sd127 : $signed(8'(q));
  endfunction

endpackage

/* rtl/core/rgb_to_maxwell_plot_coordinate.sv */
// Top level: RGB pixel to Maxwell triangle hundredths and plot coordinates.
// Between input and output lie the log, square and sum stages, the square root and divider
// pipelines (one result bit per stage each), and the M, A, H and output registers.
// Throughput is one item per cycle; busy_o is always low and results are never held.
// Reset clears all valid bits at once; items in flight at reset are dropped.
module rgb_to_maxwell_plot_coordinate #(
  parameter int unsigned FRAC_BITS = rmpc_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  output logic              valid_o,
  output logic signed [7:0] axis_one_hundredths_o,
  output logic signed [7:0] axis_two_hundredths_o,
  output logic [8:0]        plot_column_o,
  output logic [8:0]        plot_row_o,
  output logic              white_flag_o
);
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned XW   = F + 3;
  localparam int unsigned SH   = (F > rmpc_pkg::SQ_LIMIT) ? F - rmpc_pkg::SQ_LIMIT : 0;
  localparam int unsigned XSW  = XW - SH;
  localparam int unsigned SUMW = 2 * XSW + 2;
  localparam int unsigned RW   = XSW + 1;
  localparam int unsigned MAGW = RW + SH;
  localparam int unsigned NW   = XW + F;
  localparam int unsigned QW   = F + 2;
  localparam int unsigned LAT  = 3 + RW + QW + 4;

  localparam logic [MAGW-1:0] LIMIT = MAGW'((64'd1 << F) / 10000);
  localparam logic [F-1:0] R2  = F'(rmpc_pkg::isqrt_c(64'd1 << (2 * F - 1)));
  localparam logic [F-1:0] R6  = F'(rmpc_pkg::isqrt_c((64'd1 << (2 * F)) / 6));
  localparam logic [F-1:0] S23 = F'(rmpc_pkg::isqrt_c((64'd1 << (2 * F + 1)) / 3));

  // The receiver takes every result, so the pipeline never stalls.
  assign busy_o = 1'b0;

  // Constant tables: channel code to log distance, and hundredths to plot position.
  // The plot position depends only on the 8-bit hundredths value, so it is a lookup.
  logic [XW-1:0] xtbl   [256];
  logic [8:0]    coltbl [256];
  logic [8:0]    rowtbl [256];
  for (genvar g = 0; g < 256; g++) begin : g_tbl
    localparam logic [XW-1:0] XV = XW'(rmpc_pkg::log_x(g, F));
    localparam logic [8:0]    CV = rmpc_pkg::plot_col(g, F);
    localparam logic [8:0]    RV = rmpc_pkg::plot_row(g, F);
    assign xtbl[g]   = XV;
    assign coltbl[g] = CV;
    assign rowtbl[g] = RV;
  end

  // Stage 1: log lookup for each channel.
  logic          v1_q;
  logic [XW-1:0] x1_q [3];
  // Stage 2: squares, with the log values carried along.
  logic          v2_q;
  logic [XW-1:0] x2_q [3];
  logic [2*XSW-1:0] sq_q [3];
  // Stage 3: sum of squares.
  logic          v3_q;
  logic [XW-1:0] x3_q [3];
  logic [SUMW-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i & ~busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q[0] <= xtbl[red_i];
    x1_q[1] <= xtbl[green_i];
    x1_q[2] <= xtbl[blue_i];
    for (int i = 0; i < 3; i++) begin
      x2_q[i] <= x1_q[i];
      sq_q[i] <= (2 * XSW)'(x1_q[i] >> SH) * (2 * XSW)'(x1_q[i] >> SH);
      x3_q[i] <= x2_q[i];
    end
    sum_q <= SUMW'(sq_q[0]) + SUMW'(sq_q[1]) + SUMW'(sq_q[2]);
  end

  // Square root of the sum gives the vector magnitude; the log values ride along.
  logic            vs;
  logic [RW-1:0]   root;
  logic [3*XW-1:0] xs_sb;
  rmpc_isqrt #(
    .IW (SUMW),
    .RW (RW),
    .SBW(3 * XW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v3_q),
    .v_i    (sum_q),
    .sb_i   ({x3_q[0], x3_q[1], x3_q[2]}),
    .valid_o(vs),
    .root_o (root),
    .sb_o   (xs_sb)
  );

  // A magnitude at or below the threshold marks a white pixel.
  logic [MAGW-1:0] mag;
  logic            white;
  logic [NW-1:0]   num [3];
  assign mag    = MAGW'(root) << SH;
  assign white  = (mag <= LIMIT);
  assign num[0] = NW'(xs_sb[3*XW-1:2*XW]) << F;
  assign num[1] = NW'(xs_sb[2*XW-1:XW]) << F;
  assign num[2] = NW'(xs_sb[XW-1:0]) << F;

  logic          vd;
  logic [QW-1:0] quot [3];
  logic          white_d;
  rmpc_div #(
    .NW  (NW),
    .DENW(MAGW),
    .QW  (QW),
    .SBW (1)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(vs),
    .num_i  (num),
    .den_i  (mag),
    .sb_i   (white),
    .valid_o(vd),
    .quot_o (quot),
    .sb_o   (white_d)
  );

  // The unit vector is zero for a white pixel, whatever the divider produced.
  logic [QW-1:0] u [3];
  logic          neg1;
  logic [QW-1:0] dmag;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i] = white_d ? '0 : quot[i];
    end
    neg1 = (u[1] > u[0]);
    dmag = neg1 ? (u[1] - u[0]) : (u[0] - u[1]);
  end

  // Stage M: projection products. The first axis uses sign and magnitude so that
  // truncation goes toward zero.
  logic            vm_q;
  logic            wm_q;
  logic            nm_q;
  logic [QW+F-1:0] p1_q;
  logic [QW+F-1:0] p2a_q;
  logic [QW+F:0]   p2b_q;
  // Stage A: axis values in fixed point.
  logic                   va_q;
  logic                   wa_q;
  logic                   na_q;
  logic [QW-1:0]          a1m_q;
  logic signed [QW+1:0]   a2_q;
  // Stage H: hundredths.
  logic              vh_q;
  logic              wh_q;
  logic signed [7:0] h1_q;
  logic signed [7:0] h2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q    <= 1'b0;
      va_q    <= 1'b0;
      vh_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      vm_q    <= vd;
      va_q    <= vm_q;
      vh_q    <= va_q;
      valid_o <= vh_q;
    end
  end

  logic                 neg2;
  logic [QW+1:0]        a2m;
  logic [9:0]           q1;
  logic [9:0]           q2;
  always_comb begin
    neg2 = a2_q[QW+1];
    a2m  = neg2 ? (QW+2)'(-a2_q) : (QW+2)'(a2_q);
    q1   = 10'(((QW + 8)'(a1m_q) * (QW + 8)'(100)) >> F);
    q2   = 10'(((QW + 9)'(a2m) * (QW + 9)'(100)) >> F);
  end

  always_ff @(posedge clk_i) begin
    wm_q  <= white_d;
    nm_q  <= neg1;
    p1_q  <= (QW + F)'(dmag) * (QW + F)'(R2);
    p2a_q <= (QW + F)'(u[2]) * (QW + F)'(S23);
    p2b_q <= (QW + F + 1)'((QW + 1)'(u[0]) + (QW + 1)'(u[1])) * (QW + F + 1)'(R6);

    wa_q  <= wm_q;
    na_q  <= nm_q;
    a1m_q <= QW'(p1_q >> F);
    a2_q  <= $signed((QW + 2)'(p2a_q >> F)) - $signed((QW + 2)'(p2b_q >> F));

    wh_q  <= wa_q;
    h1_q  <= rmpc_pkg::hund(na_q, q1);
    h2_q  <= rmpc_pkg::hund(neg2, q2);

    // The tables are indexed by the two's complement code of the hundredths.
    white_flag_o          <= wh_q;
    axis_one_hundredths_o <= h1_q;
    axis_two_hundredths_o <= h2_q;
    plot_column_o         <= coltbl[$unsigned(h1_q)];
    plot_row_o            <= rowtbl[$unsigned(h2_q)];
  end

  // Every accepted item comes out after the fixed pipeline latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT valid_o)
    else $error("accepted item did not produce a result at the expected latency");

  // A white pixel maps to the triangle center.
  a_white_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && white_flag_o) |->
      (axis_one_hundredths_o == 8'sd0 && axis_two_hundredths_o == 8'sd0 &&
       plot_column_o == 9'd250 && plot_row_o == 9'd288))
    else $error("white pixel not at triangle center");

  // The first axis stays within the range that a unit vector allows.
  a_axis_one_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (axis_one_hundredths_o <= 8'sd72 && axis_one_hundredths_o >= -8'sd72))
    else $error("first axis hundredths out of range");
endmodule

/* rtl/core/rmpc_isqrt.sv */
// Pipelined integer square root, one result bit per stage, with a sideband carried along.
module rmpc_isqrt #(
  parameter int unsigned IW  = 48,
  parameter int unsigned RW  = 24,
  parameter int unsigned SBW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [IW-1:0]  v_i,
  input  logic [SBW-1:0] sb_i,
  output logic           valid_o,
  output logic [RW-1:0]  root_o,
  output logic [SBW-1:0] sb_o
);
  localparam int unsigned TW = IW + 1;

  logic [IW-1:0]  rem_q  [RW];
  logic [RW-1:0]  root_q [RW];
  logic [SBW-1:0] sb_q   [RW];
  logic           vld_q  [RW];

  for (genvar s = 0; s < RW; s++) begin : g_st
    localparam int unsigned B = RW - 1 - s;
    logic [IW-1:0]  rem_in;
    logic [RW-1:0]  root_in;
    logic [SBW-1:0] sb_in;
    logic           v_in;
    logic [TW-1:0]  trial;
    if (s == 0) begin : g_first
      assign rem_in  = v_i;
      assign root_in = '0;
      assign sb_in   = sb_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign sb_in   = sb_q[s-1];
      assign v_in    = vld_q[s-1];
    end
    assign trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if ({1'b0, rem_in} >= trial) begin
        rem_q[s]  <= IW'({1'b0, rem_in} - trial);
        root_q[s] <= root_in | (RW'(1) << B);
      end else begin
        rem_q[s]  <= rem_in;
        root_q[s] <= root_in;
      end
      sb_q[s] <= sb_in;
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign sb_o    = sb_q[RW-1];
endmodule

/* rtl/core/rmpc_div.sv */
// Pipelined restoring divider, three numerator lanes over one shared divisor.
module rmpc_div #(
  parameter int unsigned NW   = 43,
  parameter int unsigned DENW = 24,
  parameter int unsigned QW   = 22,
  parameter int unsigned SBW  = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [NW-1:0]   num_i [3],
  input  logic [DENW-1:0] den_i,
  input  logic [SBW-1:0]  sb_i,
  output logic            valid_o,
  output logic [QW-1:0]   quot_o [3],
  output logic [SBW-1:0]  sb_o
);
  localparam int unsigned DW = DENW + QW;

  logic [DW-1:0]   rem_q  [QW][3];
  logic [QW-1:0]   quo_q  [QW][3];
  logic [DENW-1:0] den_q  [QW];
  logic [SBW-1:0]  sb_q   [QW];
  logic            vld_q  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_st
    localparam int unsigned B = QW - 1 - s;
    logic [DW-1:0]   rem_in [3];
    logic [QW-1:0]   quo_in [3];
    logic [DENW-1:0] den_in;
    logic [SBW-1:0]  sb_in;
    logic            v_in;
    logic [DW-1:0]   dsh;
    if (s == 0) begin : g_first
      for (genvar l = 0; l < 3; l++) begin : g_l
        assign rem_in[l] = DW'(num_i[l]);
        assign quo_in[l] = '0;
      end
      assign den_in = den_i;
      assign sb_in  = sb_i;
      assign v_in   = valid_i;
    end else begin : g_next
      for (genvar l = 0; l < 3; l++) begin : g_l
        assign rem_in[l] = rem_q[s-1][l];
        assign quo_in[l] = quo_q[s-1][l];
      end
      assign den_in = den_q[s-1];
      assign sb_in  = sb_q[s-1];
      assign v_in   = vld_q[s-1];
    end
    assign dsh = DW'(den_in) << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      for (int l = 0; l < 3; l++) begin
        if (rem_in[l] >= dsh) begin
          rem_q[s][l] <= rem_in[l] - dsh;
          quo_q[s][l] <= quo_in[l] | (QW'(1) << B);
        end else begin
          rem_q[s][l] <= rem_in[l];
          quo_q[s][l] <= quo_in[l];
        end
      end
      den_q[s] <= den_in;
      sb_q[s]  <= sb_in;
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quo_q[QW-1];
  assign sb_o    = sb_q[QW-1];
endmodule
